/* hw/rtl/button_debounce_typematic_macros.svh */
// assertion macros for the button debounce / typematic block
// used by the top level only; expects clk and rst_n in scope
`ifndef BUTTON_DEBOUNCE_TYPEMATIC_MACROS_SVH
`define BUTTON_DEBOUNCE_TYPEMATIC_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BDT_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define BDT_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

/* hw/rtl/bdt_pkg.sv */
// shared types and constants for the button debounce / typematic block
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package bdt_pkg;

  localparam int unsigned CNT_W     = 16;
  localparam int unsigned CODE_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // register reset values
  localparam logic             ACT_LVL_RST    = 1'b0;
  localparam logic [CNT_W-1:0] DBN_TICKS_RST  = 16'd100;
  localparam logic [CNT_W-1:0] LONG_TICKS_RST = 16'd3000;
  localparam logic [CNT_W-1:0] RPT_TICKS_RST  = 16'd500;

  // event codes on the result channel
  typedef enum logic [CODE_W-1:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_LONG    = 3'd2,
    EV_REPEAT  = 3'd3,
    EV_RELEASE = 3'd4
  } ev_code_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_LEVEL = 2'd0,
    CFG_DEBOUNCE     = 2'd1,
    CFG_LONG_PRESS   = 2'd2,
    CFG_REPEAT       = 2'd3
  } cfg_idx_t;

endpackage

`default_nettype wire

/* hw/rtl/bdt_channels.sv */
// valid/ready channel interfaces: pin tick in, event out, register write
// depends on bdt_pkg for field widths
`default_nettype none

interface bdt_tick_if import bdt_pkg::*; ();
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

interface bdt_event_if import bdt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

interface bdt_cfg_if import bdt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/button_debounce_typematic.sv */
// button debouncer with long press and autorepeat, one button
// depends on bdt_pkg, bdt_channels and button_debounce_typematic_macros.svh
//
//   channel   dir  payload                 accepted when
//   in_tick   in   pin_level [0:0]         in_tick.valid & in_tick.ready
//   out_evt   out  event_code [2:0]        out_evt.valid & out_evt.ready
//   cfg_wr    in   index [1:0], data [15:0] cfg_wr.valid & cfg_wr.ready
//
// one tick is taken per cycle while in_tick.ready is high; its event word appears in
// the result register the cycle after acceptance, set by the single state update between the two
// in_tick.ready drops only while an event word waits and out_evt.ready is low
// cfg_wr.ready is always high; a write takes effect at the next edge
// reset (synchronous, rst_n low) loads the register defaults and clears state
`default_nettype none
`include "button_debounce_typematic_macros.svh"

module button_debounce_typematic import bdt_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bdt_tick_if.sink    in_tick,
  bdt_event_if.source out_evt,
  bdt_cfg_if.sink     cfg_wr
);

  typedef enum logic [1:0] {
    MODE_RELEASED = 2'd0,
    MODE_PRESSED  = 2'd1,
    MODE_REPEAT   = 2'd2
  } mode_t;

  // configuration registers
  logic             act_lvl_r;
  logic [CNT_W-1:0] dbn_ticks_r;
  logic [CNT_W-1:0] long_ticks_r;
  logic [CNT_W-1:0] rpt_ticks_r;

  // button state
  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] dbn_r, dbn_nxt;
  logic [CNT_W-1:0] tmo_r, tmo_nxt;

  // result register
  logic     out_vld_r;
  ev_code_t code_r, code_nxt;

  logic in_acc;
  logic active;
  logic press;
  logic release_ev;
  logic timeout;
  logic [CNT_W-1:0] tmo_dec;

  assign in_tick.ready      = !out_vld_r || out_evt.ready;
  assign in_acc             = in_tick.valid && in_tick.ready;
  assign out_evt.valid      = out_vld_r;
  assign out_evt.event_code = code_r;
  assign cfg_wr.ready       = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_lvl_r    <= ACT_LVL_RST;
      dbn_ticks_r  <= DBN_TICKS_RST;
      long_ticks_r <= LONG_TICKS_RST;
      rpt_ticks_r  <= RPT_TICKS_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_ACTIVE_LEVEL: act_lvl_r    <= cfg_wr.data[0];
        CFG_DEBOUNCE:     dbn_ticks_r  <= cfg_wr.data[CNT_W-1:0];
        CFG_LONG_PRESS:   long_ticks_r <= cfg_wr.data[CNT_W-1:0];
        CFG_REPEAT:       rpt_ticks_r  <= cfg_wr.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // debounce and timer steps, then one event
  always_comb begin
    active     = (in_tick.pin_level == act_lvl_r);
    press      = 1'b0;
    release_ev = 1'b0;
    dbn_nxt    = dbn_r;
    if (dbn_r == '0) begin
      press      = active && (mode_r == MODE_RELEASED);
      release_ev = !active && (mode_r != MODE_RELEASED);
      if (press || release_ev) begin
        dbn_nxt = dbn_ticks_r;
      end
    end else begin
      dbn_nxt = dbn_r - CNT_W'(1);
    end

    // hold / repeat timer counts down and fires when it reaches one
    tmo_dec = (tmo_r != '0) ? (tmo_r - CNT_W'(1)) : '0;
    timeout = (tmo_r == CNT_W'(1));

    mode_nxt = mode_r;
    tmo_nxt  = tmo_dec;
    code_nxt = EV_NONE;
    priority if (press) begin
      mode_nxt = MODE_PRESSED;
      tmo_nxt  = long_ticks_r;
      code_nxt = EV_PRESS;
    end else if (release_ev) begin
      mode_nxt = MODE_RELEASED;
      tmo_nxt  = '0;
      code_nxt = EV_RELEASE;
    end else if (timeout && (mode_r != MODE_RELEASED)) begin
      tmo_nxt = rpt_ticks_r;
      if (mode_r == MODE_PRESSED) begin
        mode_nxt = MODE_REPEAT;
        code_nxt = EV_LONG;
      end else begin
        code_nxt = EV_REPEAT;
      end
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_RELEASED;
      dbn_r     <= '0;
      tmo_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_r    <= mode_nxt;
        dbn_r     <= dbn_nxt;
        tmo_r     <= tmo_nxt;
        out_vld_r <= 1'b1;
      end else if (out_evt.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      code_r <= code_nxt;
    end
  end

  // checks
  `BDT_ASSERT_NOW(a_released_no_timer, mode_r == MODE_RELEASED, tmo_r == '0, "timer running while released")
  `BDT_ASSERT_NEXT(a_acc_gives_word, in_acc, out_vld_r, "accepted tick produced no event word")
  `BDT_ASSERT_NEXT(a_edge_loads_dbn, in_acc && (code_nxt == EV_PRESS || code_nxt == EV_RELEASE), dbn_r == $past(dbn_ticks_r), "debounce not restarted on level change")
  `BDT_ASSERT_NEXT(a_long_enters_rpt, in_acc && code_nxt == EV_LONG, mode_r == MODE_REPEAT, "long press did not enter repeat mode")

endmodule

`default_nettype wire
